// File: sv/psbr_pkg.sv
package psbr_pkg;

  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned POS_W       = 48;
  localparam int unsigned OIB_W       = 16;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned LOG2_MIN    = 9;
  localparam int unsigned LOG2_MAX    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_BLOCK_LOG2   = 3'd3,
    REG_START_OFFSET = 3'd4,
    REG_LAST_OFFSET  = 3'd5
  } cfg_reg_e;

  typedef logic [PATTERN_MAX-1:0][7:0] window_t;
  typedef logic [PATTERN_MAX-1:0][7:0] pattern_t;

  typedef struct packed {
    logic [POS_W-1:0] block_offset;
    logic [OIB_W-1:0] offset_in_block;
  } result_t;

  // Pattern length as used: zero counts as one, anything above the maximum is clamped.
  function automatic logic [CNT_W-1:0] eff_len(input logic [4:0] raw);
    logic [CNT_W-1:0] len;
    if (raw == 5'd0) begin
      len = CNT_W'(1);
    end else if (32'(raw) > PATTERN_MAX) begin
      len = CNT_W'(PATTERN_MAX);
    end else begin
      len = CNT_W'(raw);
    end
    return len;
  endfunction

  function automatic logic [4:0] eff_log2(input logic [4:0] raw);
    logic [4:0] lg;
    if (32'(raw) < LOG2_MIN) begin
      lg = 5'(LOG2_MIN);
    end else if (32'(raw) > LOG2_MAX) begin
      lg = 5'(LOG2_MAX);
    end else begin
      lg = raw;
    end
    return lg;
  endfunction

endpackage

// File: sv/psbr_match.sv
module psbr_match (
  input  psbr_pkg::window_t           window_i,
  input  psbr_pkg::pattern_t          pattern_i,
  input  logic [psbr_pkg::CNT_W-1:0]  len_i,
  output logic                        match_o
);

  logic [psbr_pkg::PATTERN_MAX-1:0] ok;

  // Window entry k (newest at 0) lines up with pattern byte len-1-k.
  always_comb begin
    logic [psbr_pkg::CNT_W-1:0] pidx;
    for (int k = 0; k < psbr_pkg::PATTERN_MAX; k++) begin
      pidx = len_i - psbr_pkg::CNT_W'(1) - psbr_pkg::CNT_W'(k);
      if (psbr_pkg::CNT_W'(k) < len_i) begin
        ok[k] = (window_i[k] == pattern_i[pidx[$clog2(psbr_pkg::PATTERN_MAX)-1:0]]);
      end else begin
        ok[k] = 1'b1;
      end
    end
  end

  assign match_o = &ok;

endmodule

// File: sv/pattern_search_block_report.sv
// Scans a byte stream for a pattern of 1 to 16 bytes and reports each
// non-overlapping match by its start offset, split into a block-aligned offset
// and an offset inside a power-of-two block. One byte beat is taken every
// cycle unless the input is stalled; the window compare, range check and
// offset math sit between the stream state registers and a two-entry output
// buffer, which registers each result into its output or skid entry. The
// input stalls only while both output entries hold results that have not been
// taken. A byte with restart set starts at start_offset with an empty window.
// Configuration writes take effect from the next byte.
module pattern_search_block_report (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [psbr_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [psbr_pkg::POS_W-1:0]      block_offset_o,
  output logic [psbr_pkg::OIB_W-1:0]      offset_in_block_o
);

  localparam int unsigned POS_W = psbr_pkg::POS_W;
  localparam int unsigned CNT_W = psbr_pkg::CNT_W;

  logic [63:0]      pat_low_q, pat_high_q;
  logic [4:0]       pat_len_q, blk_log2_q;
  logic [POS_W-1:0] start_off_q, last_off_q;

  psbr_pkg::window_t win_q, win_d, win_base;
  logic [CNT_W-1:0]  seen_q, seen_d, seen_base;
  logic [CNT_W-1:0]  skip_q, skip_d, skip_base;
  logic [POS_W-1:0]  pos_q, pos_d, pos_cur;

  psbr_pkg::result_t out_q, out_d, skid_q, skid_d, res;
  logic              out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  logic              accept, match, hit, out_free;
  logic [CNT_W-1:0]  len;
  logic [4:0]        lg;
  logic [POS_W-1:0]  start_pos, bmask;

  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign len        = psbr_pkg::eff_len(pat_len_q);
  assign lg         = psbr_pkg::eff_log2(blk_log2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q   <= '0;
      pat_high_q  <= '0;
      pat_len_q   <= 5'd1;
      blk_log2_q  <= 5'(psbr_pkg::LOG2_MIN);
      start_off_q <= '0;
      last_off_q  <= '0;
    end else if (cfg_we_i) begin
      case (psbr_pkg::cfg_reg_e'(cfg_idx_i))
        psbr_pkg::REG_PATTERN_LOW:  pat_low_q   <= cfg_data_i;
        psbr_pkg::REG_PATTERN_HIGH: pat_high_q  <= cfg_data_i;
        psbr_pkg::REG_PATTERN_LEN:  pat_len_q   <= cfg_data_i[4:0];
        psbr_pkg::REG_BLOCK_LOG2:   blk_log2_q  <= cfg_data_i[4:0];
        psbr_pkg::REG_START_OFFSET: start_off_q <= cfg_data_i[POS_W-1:0];
        psbr_pkg::REG_LAST_OFFSET:  last_off_q  <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // A restart clears the window and counters before the byte is shifted in.
  always_comb begin
    win_base  = restart_i ? '0 : win_q;
    seen_base = restart_i ? '0 : seen_q;
    skip_base = restart_i ? '0 : skip_q;
    pos_cur   = restart_i ? start_off_q : pos_q;

    win_d = {win_base[psbr_pkg::PATTERN_MAX-2:0], data_byte_i};
    seen_d = (seen_base < CNT_W'(psbr_pkg::PATTERN_MAX)) ? seen_base + CNT_W'(1) : seen_base;
    pos_d = pos_cur + POS_W'(1);
  end

  psbr_match u_match (
    .window_i  (win_d),
    .pattern_i ({pat_high_q, pat_low_q}),
    .len_i     (len),
    .match_o   (match)
  );

  always_comb begin
    hit    = (skip_base == '0) && (seen_d >= len) && (pos_cur < last_off_q) && match;
    skip_d = (skip_base != '0) ? skip_base - CNT_W'(1) :
             hit ? len - CNT_W'(1) : '0;

    start_pos = pos_cur - POS_W'(len - CNT_W'(1));
    bmask     = (POS_W'(1) << lg) - POS_W'(1);
    res.block_offset    = start_pos & ~bmask;
    res.offset_in_block = start_pos[psbr_pkg::OIB_W-1:0] & bmask[psbr_pkg::OIB_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= '0;
      skip_q <= '0;
      pos_q  <= '0;
    end else if (accept) begin
      win_q  <= win_d;
      seen_q <= seen_d;
      skip_q <= skip_d;
      pos_q  <= pos_d;
    end
  end

  // Two-entry output buffer: the skid entry fills only when the output
  // entry is held, and it drains first once the output entry frees up.
  always_comb begin
    out_free   = !out_vld_q || !out_stall_i;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (out_free) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (out_free) begin
      out_d     = res;
      out_vld_d = accept && hit;
    end else if (accept && hit) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_vld_q;
  assign block_offset_o    = out_q.block_offset;
  assign offset_in_block_o = out_q.offset_in_block;

endmodule

// File: sv/psbr_checker.sv
module psbr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [psbr_pkg::POS_W-1:0]  block_offset_o,
  input logic [psbr_pkg::OIB_W-1:0]  offset_in_block_o
);

  // A held result beat stays valid.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A held result beat keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(block_offset_o) && $stable(offset_in_block_o))
    else $error("result payload changed while stalled");

  // With nothing buffered and no byte taken, no result can appear.
  a_no_invent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared without an accepted byte");

  // The input backs up only behind a held result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

endmodule

bind pattern_search_block_report psbr_checker u_psbr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .block_offset_o    (block_offset_o),
  .offset_in_block_o (offset_in_block_o)
);

// File: tb/pattern_search_block_report_test.sv
`timescale 1ns / 100ps

module pattern_search_block_report_test;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_CAP   = 200;

  typedef struct packed {
    logic [7:0] value;
    logic       restart;
  } stream_beat_t;

  logic                          clk            = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we         = 1'b0;
  psbr_pkg::cfg_reg_e            cfg_idx        = psbr_pkg::REG_PATTERN_LOW;
  logic [psbr_pkg::CFG_W-1:0]    cfg_data       = '0;
  logic                          in_valid       = 1'b0;
  logic                          in_stall;
  logic [7:0]                    data_byte      = 8'h00;
  logic                          restart        = 1'b0;
  logic                          out_valid;
  logic                          out_stall      = 1'b0;
  logic [psbr_pkg::POS_W-1:0]    block_offset;
  logic [psbr_pkg::OIB_W-1:0]    offset_in_block;

  pattern_search_block_report uut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .restart_i         (restart),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .block_offset_o    (block_offset),
    .offset_in_block_o (offset_in_block)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the search state and the registers.
  logic [63:0]                pat_lo    = '0;
  logic [63:0]                pat_hi    = '0;
  logic [4:0]                 len_reg   = 5'd1;
  logic [4:0]                 log2_reg  = 5'd9;
  logic [psbr_pkg::POS_W-1:0] start_off = '0;
  logic [psbr_pkg::POS_W-1:0] last_off  = '0;
  psbr_pkg::window_t          win       = '0;
  int unsigned                seen      = 0;
  int unsigned                skip      = 0;
  logic [psbr_pkg::POS_W-1:0] next_pos  = '0;

  stream_beat_t        bytes_to_send[$];
  psbr_pkg::result_t   expected_hits[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_left    = 0;
  bit          beat_taken   = 1'b0;
  int unsigned errors       = 0;
  int unsigned bytes_taken  = 0;
  int unsigned hits_seen    = 0;
  int unsigned stall_beats  = 0;
  int unsigned setups       = 0;
  int unsigned cycles       = 0;
  bit          narrow       = 1'b0;
  logic [7:0]  alpha_a      = 8'h00;
  logic [7:0]  alpha_b      = 8'h00;

  function automatic int unsigned match_len();
    if (len_reg == 5'd0) return 1;
    if (int'(len_reg) > psbr_pkg::PATTERN_MAX) return psbr_pkg::PATTERN_MAX;
    return len_reg;
  endfunction

  function automatic int unsigned block_bits();
    if (int'(log2_reg) < psbr_pkg::LOG2_MIN) return psbr_pkg::LOG2_MIN;
    if (int'(log2_reg) > psbr_pkg::LOG2_MAX) return psbr_pkg::LOG2_MAX;
    return log2_reg;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned i);
    logic [127:0] all;
    all = {pat_hi, pat_lo};
    return all[8*i +: 8];
  endfunction

  // Advances the mirrored state by one byte and queues the match it completes, if any.
  function automatic void scan_byte(input logic [7:0] b, input logic rs);
    int unsigned                len;
    int unsigned                i;
    logic [psbr_pkg::POS_W-1:0] pos;
    logic [psbr_pkg::POS_W-1:0] first;
    logic [psbr_pkg::POS_W-1:0] blk_mask;
    bit                         hit;
    psbr_pkg::result_t          r;
    len = match_len();
    if (rs) begin
      win = '0;
      seen = 0;
      skip = 0;
      next_pos = start_off;
    end
    pos = next_pos;
    next_pos = next_pos + 48'd1;
    win = {win[psbr_pkg::PATTERN_MAX-2:0], b};
    if (seen < psbr_pkg::PATTERN_MAX) seen++;
    if (skip > 0) begin
      skip--;
      return;
    end
    if (seen < len || pos >= last_off) return;
    hit = 1'b1;
    for (i = 0; i < len; i++) begin
      if (win[len-1-i] != pattern_byte(i)) hit = 1'b0;
    end
    if (!hit) return;
    // Scanning resumes after the end of the match, so the next len-1 bytes cannot end one.
    skip = len - 1;
    first = pos - 48'(len - 1);
    blk_mask = (48'd1 << block_bits()) - 48'd1;
    r.block_offset = first & ~blk_mask;
    r.offset_in_block = 16'(first & blk_mask);
    expected_hits = {expected_hits, r};
  endfunction

  task automatic flag_error(input string msg);
    if (errors < PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst_ni && (!in_valid || beat_taken)) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        data_byte <= bytes_to_send[0].value;
        restart <= bytes_to_send[0].restart;
        void'(bytes_to_send.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  // Receiver: a requested hold-off is counted down here, otherwise it stalls at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Monitor. The output is checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin : watch
    psbr_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          flag_error($sformatf("unexpected match block 0x%h offset 0x%h",
                               block_offset, offset_in_block));
        end else begin
          want = expected_hits.pop_front();
          hits_seen++;
          if (block_offset !== want.block_offset)
            flag_error($sformatf("block_offset 0x%h, expected 0x%h",
                                 block_offset, want.block_offset));
          if (offset_in_block !== want.offset_in_block)
            flag_error($sformatf("offset_in_block 0x%h, expected 0x%h",
                                 offset_in_block, want.offset_in_block));
        end
      end
      if (in_valid && in_stall) stall_beats++;
      if (in_valid && !in_stall) begin
        scan_byte(data_byte, restart);
        beat_taken = 1'b1;
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d matches outstanding",
               cycles, expected_hits.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic feed(input logic [7:0] b, input logic rs);
    stream_beat_t beat;
    beat.value = b;
    beat.restart = rs;
    bytes_to_send = {bytes_to_send, beat};
  endtask

  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid || expected_hits.size() != 0)
      @(posedge clk);
    // A byte that completes no match may still be in flight.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input psbr_pkg::cfg_reg_e idx,
                           input logic [psbr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      psbr_pkg::REG_PATTERN_LOW:  pat_lo = val;
      psbr_pkg::REG_PATTERN_HIGH: pat_hi = val;
      psbr_pkg::REG_PATTERN_LEN:  len_reg = val[4:0];
      psbr_pkg::REG_BLOCK_LOG2:   log2_reg = val[4:0];
      psbr_pkg::REG_START_OFFSET: start_off = val[psbr_pkg::POS_W-1:0];
      psbr_pkg::REG_LAST_OFFSET:  last_off = val[psbr_pkg::POS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [psbr_pkg::POS_W-1:0] rand_pos();
    return {16'($urandom), $urandom};
  endfunction

  task automatic run_directed();
    int unsigned i;
    // Before any restart bytes count from zero, and the empty range allows no match.
    feed(8'hFF, 1'b0);
    wait_idle();
    // Four-byte match straddling the wrap of the position counter.
    write_reg(psbr_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_A55A_FF00);
    write_reg(psbr_pkg::REG_PATTERN_HIGH, '1);
    write_reg(psbr_pkg::REG_PATTERN_LEN, 64'd4);
    write_reg(psbr_pkg::REG_BLOCK_LOG2, 64'd9);
    write_reg(psbr_pkg::REG_START_OFFSET, 64'hFFFF_FFFF_FFFE);
    write_reg(psbr_pkg::REG_LAST_OFFSET, 64'hFFFF_FFFF_FFFF);
    feed(8'h00, 1'b1);
    feed(8'hFF, 1'b0);
    feed(8'h5A, 1'b0);
    feed(8'hA5, 1'b0);
    wait_idle();
    // Repeated byte pair: matches must not overlap. Block size below the minimum.
    write_reg(psbr_pkg::REG_PATTERN_LOW, 64'h7777);
    write_reg(psbr_pkg::REG_PATTERN_LEN, 64'd2);
    write_reg(psbr_pkg::REG_BLOCK_LOG2, 64'd0);
    write_reg(psbr_pkg::REG_START_OFFSET, 64'h1234_5678_9ABC);
    for (i = 0; i < 4; i++) feed(8'h77, i == 0);
    wait_idle();
    // Zero length acts as one; a match ending at the range end is dropped.
    write_reg(psbr_pkg::REG_PATTERN_LOW, 64'h11);
    write_reg(psbr_pkg::REG_PATTERN_LEN, 64'd0);
    write_reg(psbr_pkg::REG_BLOCK_LOG2, 64'd31);
    write_reg(psbr_pkg::REG_START_OFFSET, 64'd100);
    write_reg(psbr_pkg::REG_LAST_OFFSET, 64'd101);
    feed(8'h11, 1'b1);
    feed(8'h11, 1'b0);
    wait_idle();
    // Oversized length acts as the full sixteen bytes; the match ends just inside the range.
    write_reg(psbr_pkg::REG_PATTERN_LOW, 64'h0706_0504_0302_0100);
    write_reg(psbr_pkg::REG_PATTERN_HIGH, 64'hF0E0_D0C0_B0A0_9080);
    write_reg(psbr_pkg::REG_PATTERN_LEN, 64'd31);
    write_reg(psbr_pkg::REG_BLOCK_LOG2, 64'd12);
    write_reg(psbr_pkg::REG_START_OFFSET, 64'd0);
    write_reg(psbr_pkg::REG_LAST_OFFSET, 64'd16);
    for (i = 0; i < psbr_pkg::PATTERN_MAX; i++) feed(pattern_byte(i), i == 0);
    wait_idle();
  endtask

  task automatic random_setup();
    logic [127:0]               pat;
    logic [psbr_pkg::POS_W-1:0] st;
    logic [psbr_pkg::POS_W-1:0] lst;
    int unsigned                i;
    int unsigned                pick;
    narrow = ($urandom_range(2) == 0);
    alpha_a = 8'($urandom);
    alpha_b = 8'($urandom);
    for (i = 0; i < 16; i++)
      pat[8*i +: 8] = narrow ? ($urandom_range(1) ? alpha_a : alpha_b) : 8'($urandom);
    pick = $urandom_range(9);
    if (pick <= 5) write_reg(psbr_pkg::REG_PATTERN_LEN, 64'($urandom_range(1, 4)));
    else if (pick <= 7) write_reg(psbr_pkg::REG_PATTERN_LEN, 64'($urandom_range(5, 16)));
    else if (pick == 8) write_reg(psbr_pkg::REG_PATTERN_LEN,
                                  $urandom_range(1) ? 64'd0 : 64'($urandom_range(17, 31)));
    else write_reg(psbr_pkg::REG_PATTERN_LEN, 64'd16);
    write_reg(psbr_pkg::REG_PATTERN_LOW, pat[63:0]);
    write_reg(psbr_pkg::REG_PATTERN_HIGH, pat[127:64]);
    write_reg(psbr_pkg::REG_BLOCK_LOG2, $urandom_range(3) != 0 ? 64'($urandom_range(9, 16))
                                                               : 64'($urandom_range(0, 31)));
    pick = $urandom_range(7);
    if (pick <= 3) st = rand_pos();
    else if (pick <= 5) st = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(200));
    else st = '0;
    write_reg(psbr_pkg::REG_START_OFFSET, 64'(st));
    pick = $urandom_range(9);
    if (pick <= 5) lst = 48'hFFFF_FFFF_FFFF;
    else if (pick <= 7) lst = st + 48'($urandom_range(20, 200));
    else if (pick == 8) lst = '0;
    else lst = rand_pos();
    write_reg(psbr_pkg::REG_LAST_OFFSET, 64'(lst));
    setups++;
  endtask

  // Mostly whole copies of the pattern, some cut short, with noise bytes in between.
  task automatic queue_stream(input int unsigned n, input bit lead_restart);
    int unsigned pushed;
    int unsigned len;
    int unsigned k;
    int unsigned i;
    int unsigned pick;
    logic [7:0]  b;
    pushed = 0;
    len = match_len();
    while (pushed < n) begin
      pick = $urandom_range(9);
      if (pick <= 6) begin
        k = (pick <= 5) ? len : $urandom_range(len - 1);
        for (i = 0; i < k; i++) begin
          feed(pattern_byte(i), pushed == 0 ? lead_restart : ($urandom_range(59) == 0));
          pushed++;
        end
      end else begin
        if (narrow && $urandom_range(3) != 0) b = $urandom_range(1) ? alpha_a : alpha_b;
        else if ($urandom_range(1)) b = pattern_byte($urandom_range(len - 1));
        else b = 8'($urandom);
        feed(b, pushed == 0 ? lead_restart : ($urandom_range(59) == 0));
        pushed++;
      end
    end
  endtask

  // Receiver holds off while a one-byte pattern matches every beat, so the
  // output buffer fills and the block has to stall its input.
  task automatic squeeze_output();
    int unsigned i;
    write_reg(psbr_pkg::REG_PATTERN_LOW, 64'h3C);
    write_reg(psbr_pkg::REG_PATTERN_LEN, 64'd1);
    write_reg(psbr_pkg::REG_START_OFFSET, 64'd0);
    write_reg(psbr_pkg::REG_LAST_OFFSET, 64'hFFFF_FFFF_FFFF);
    hold_left = 60;
    for (i = 0; i < 40; i++) feed(8'h3C, i == 0);
    wait_idle();
  endtask

  initial begin : sequencer
    int unsigned phase;
    int unsigned seg;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 24;
          recv_gap_pct = 54;
        end
        1: begin
          send_gap_pct = 54;
          recv_gap_pct = 24;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      if (phase == 0) run_directed();
      if (phase == 2) squeeze_output();
      for (seg = 0; seg < 5; seg++) begin
        wait_idle();
        random_setup();
        queue_stream($urandom_range(40, 80), $urandom_range(7) != 0);
      end
      wait_idle();
    end
    repeat (10) @(posedge clk);
    if (expected_hits.size() != 0)
      flag_error($sformatf("%0d expected matches never reported", expected_hits.size()));
    $display("Scanned %0d bytes under %0d random setups plus directed cases;",
             bytes_taken, setups);
    $display("%0d matches checked, input stalled on %0d beats, %0d errors.",
             hits_seen, stall_beats, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
